// File: sv/lbp_pkg.sv
// Shared constants and types for the length-bucket partitioner.
// No dependencies; imported by lbp_div and the top level.
package lbp_pkg;

  localparam int MAX_BINS = 64;
  localparam int IDX_W    = 6;   // bin index
  localparam int BINS_W   = 7;   // bin count, 0..MAX_BINS
  localparam int CNT_W    = 22;  // prefix of counts
  localparam int WSUM_W   = 35;  // prefix of length*count
  localparam int COST_W   = 57;  // one interval cost
  localparam int ACC_W    = 58;  // cost plus a best cost
  localparam int TOT_W    = 63;  // output cost width
  localparam int LEN_W    = 13;  // absolute length
  localparam int ML_W     = 12;  // min_length register
  localparam int PCT_W    = 7;   // coverage register
  localparam int DIVN_W   = 19;  // divider dividend / quotient
  localparam int LO_MUL_W = 18;  // low slice of the weighted operand

  localparam logic CFG_MIN_LENGTH = 1'b0;
  localparam logic CFG_COVERAGE   = 1'b1;

  typedef struct packed {
    logic              start;
    logic [DIVN_W-1:0] dividend;
    logic [PCT_W-1:0]  divisor;
  } div_req_t;

  typedef struct packed {
    logic              done;
    logic [DIVN_W-1:0] quotient;
  } div_rsp_t;

endpackage

// File: sv/lbp_div.sv
// Restoring divider, one quotient bit per cycle, 7-bit divisor.
// Depends on lbp_pkg.
module lbp_div (
  input  logic              clk,
  input  logic              rst_n,
  input  lbp_pkg::div_req_t req,
  output lbp_pkg::div_rsp_t rsp
);
  import lbp_pkg::*;

  logic              busy_r, busy_nxt;
  logic              done_r, done_nxt;
  logic [4:0]        cnt_r, cnt_nxt;
  logic [PCT_W-1:0]  rem_r, rem_nxt;
  logic [DIVN_W-1:0] quo_r, quo_nxt;
  logic [PCT_W-1:0]  dvs_r, dvs_nxt;
  logic [PCT_W:0]    trial;

  always_comb begin
    busy_nxt = busy_r;
    done_nxt = 1'b0;
    cnt_nxt  = cnt_r;
    rem_nxt  = rem_r;
    quo_nxt  = quo_r;
    dvs_nxt  = dvs_r;
    trial    = {rem_r, quo_r[DIVN_W-1]};
    if (req.start) begin
      busy_nxt = 1'b1;
      cnt_nxt  = 5'(DIVN_W - 1);
      rem_nxt  = '0;
      quo_nxt  = req.dividend;
      dvs_nxt  = req.divisor;
    end else if (busy_r) begin
      if (trial >= {1'b0, dvs_r}) begin
        rem_nxt = PCT_W'(trial - {1'b0, dvs_r});
        quo_nxt = {quo_r[DIVN_W-2:0], 1'b1};
      end else begin
        rem_nxt = trial[PCT_W-1:0];
        quo_nxt = {quo_r[DIVN_W-2:0], 1'b0};
      end
      if (cnt_r == '0) begin
        busy_nxt = 1'b0;
        done_nxt = 1'b1;
      end else begin
        cnt_nxt = cnt_r - 5'd1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      busy_r <= 1'b0;
      done_r <= 1'b0;
    end else begin
      busy_r <= busy_nxt;
      done_r <= done_nxt;
    end
    cnt_r <= cnt_nxt;
    rem_r <= rem_nxt;
    quo_r <= quo_nxt;
    dvs_r <= dvs_nxt;
  end

  assign rsp.done     = done_r;
  assign rsp.quotient = quo_r;

endmodule

// File: sv/length_bucket_partition_dp.sv
// Length-bucket partitioner: optimal interval partition over a length histogram.
// Depends on lbp_pkg and lbp_div.
//
// Usage:
//   Input channel (in_valid/in_ready): one transaction per histogram bin,
//   the first bin at length min_length. Bins past 64 are dropped;
//   in_last_bin still starts the solve. Once the last bin is taken,
//   in_ready stays low for the whole solve and emit phase. The solve runs
//   row by row through one shared divider for the upper bound, a reciprocal
//   multiply for the naive lower bound and one shared cost unit (i+2 cost
//   terms for row i), followed by one total-cost term. Output channel
//   (out_valid/out_ready): one transaction per chosen interval, last to
//   first, each fetched only after the previous one is accepted;
//   out_last_interval marks the first bucket. A stalled sink simply holds
//   the output register; nothing is lost. After the final interval the
//   block clears its bin count and running sums and takes a new histogram.
//   Reset (rst_n low, synchronous) empties the histogram, drops any pending
//   output and restores min_length=1, coverage_percent=90.
//   Config writes (cfg_we) are meant only while the block is idle.
module length_bucket_partition_dp (
  input  logic                      clk,
  input  logic                      rst_n,
  input  logic                      in_valid,
  output logic                      in_ready,
  input  logic [15:0]               in_bin_count,
  input  logic                      in_last_bin,
  output logic                      out_valid,
  input  logic                      out_ready,
  output logic [lbp_pkg::LEN_W-1:0] out_interval_low,
  output logic [lbp_pkg::LEN_W-1:0] out_interval_high,
  output logic [lbp_pkg::TOT_W-1:0] out_min_cost,
  output logic [lbp_pkg::TOT_W-1:0] out_naive_cost,
  output logic [lbp_pkg::TOT_W-1:0] out_full_cost,
  output logic                      out_last_interval,
  input  logic                      cfg_we,
  input  logic                      cfg_index,
  input  logic [lbp_pkg::ML_W-1:0]  cfg_data
);
  import lbp_pkg::*;

  // sequencer states
  localparam logic [3:0] S_LOAD    = 4'd0;
  localparam logic [3:0] S_ROW     = 4'd1;   // start upper-bound division
  localparam logic [3:0] S_DIVQ    = 4'd2;
  localparam logic [3:0] S_DIVL    = 4'd3;   // naive lower bound, reciprocal of 100
  localparam logic [3:0] S_RDU     = 4'd4;
  localparam logic [3:0] S_LATU    = 4'd5;
  localparam logic [3:0] S_TADDR   = 4'd6;   // cost term: read prefixes
  localparam logic [3:0] S_TDATA   = 4'd7;   // cost term: differences
  localparam logic [3:0] S_TMUL0   = 4'd8;
  localparam logic [3:0] S_TMUL1   = 4'd9;
  localparam logic [3:0] S_TACC    = 4'd10;  // cost term: sum and compare
  localparam logic [3:0] S_WRITE   = 4'd11;
  localparam logic [3:0] S_BT_RD   = 4'd12;
  localparam logic [3:0] S_BT_OUT  = 4'd13;
  localparam logic [3:0] S_BT_WAIT = 4'd14;

  // cost term kinds
  localparam logic [1:0] K_MIN0  = 2'd0;  // no split
  localparam logic [1:0] K_MIN   = 2'd1;  // split at k
  localparam logic [1:0] K_NAIVE = 2'd2;
  localparam logic [1:0] K_FULL  = 2'd3;

  // x/100 as (x * ceil(2^26/100)) >> 26, exact for x below 2^19
  localparam int                 RECIP_W   = 20;
  localparam int                 RECIP_SH  = 26;
  localparam logic [RECIP_W-1:0] RECIP_100 = 20'd671089;
  localparam int                 LPROD_W   = DIVN_W + RECIP_W;

  logic [3:0]              state_r, state_nxt;
  logic [ML_W-1:0]         min_len_r, min_len_nxt;
  logic [PCT_W-1:0]        cov_r, cov_nxt;
  logic [BINS_W-1:0]       bins_r, bins_nxt;
  logic [BINS_W-1:0]       n_r, n_nxt;
  logic [CNT_W-1:0]        pc_run_r, pc_run_nxt;
  logic [WSUM_W-1:0]       pw_run_r, pw_run_nxt;
  logic [IDX_W-1:0]        i_r, i_nxt;
  logic [IDX_W-1:0]        k_r, k_nxt;
  logic [1:0]              kind_r, kind_nxt;
  logic [LEN_W-1:0]        upper_r, upper_nxt;
  logic [IDX_W-1:0]        uidx_r, uidx_nxt;
  logic [IDX_W-1:0]        lidx_r, lidx_nxt;
  logic [DIVN_W-1:0]       lnum_r, lnum_nxt;
  logic [WSUM_W-1:0]       wu_r, wu_nxt;
  logic [CNT_W-1:0]        cu_r, cu_nxt;
  logic [WSUM_W-1:0]       wd_r, wd_nxt;
  logic [CNT_W-1:0]        cd_r, cd_nxt;
  logic [COST_W-1:0]       badd_r, badd_nxt;
  logic [LO_MUL_W+CNT_W-1:0]        plo_r, plo_nxt;
  logic [WSUM_W-LO_MUL_W+CNT_W-1:0] phi_r, phi_nxt;
  logic [COST_W-1:0]       best_r, best_nxt;
  logic [IDX_W-1:0]        bp_r, bp_nxt;
  logic [TOT_W-1:0]        naive_r, naive_nxt;
  logic [COST_W-1:0]       full_r, full_nxt;
  logic [COST_W-1:0]       minc_r, minc_nxt;
  logic [IDX_W-1:0]        idx_r, idx_nxt;
  logic [IDX_W-1:0]        btbp_r, btbp_nxt;
  logic                    out_valid_r, out_valid_nxt;
  logic [LEN_W-1:0]        out_low_r, out_low_nxt;
  logic [LEN_W-1:0]        out_high_r, out_high_nxt;
  logic                    out_last_r, out_last_nxt;

  // memories
  logic [CNT_W-1:0]  pc_mem   [MAX_BINS];
  logic [WSUM_W-1:0] pw_mem   [MAX_BINS];
  logic [COST_W-1:0] best_mem [MAX_BINS];
  logic [IDX_W-1:0]  bp_mem   [MAX_BINS];
  logic [LEN_W-1:0]  up_mem   [MAX_BINS];
  logic [CNT_W-1:0]  pc_q;
  logic [WSUM_W-1:0] pw_q;
  logic [COST_W-1:0] best_q;
  logic [IDX_W-1:0]  bp_q;
  logic [LEN_W-1:0]  up_q;
  logic [IDX_W-1:0]  rd_addr;
  logic              load_we;
  logic              row_we;

  div_req_t div_req;
  div_rsp_t div_rsp;

  logic               in_acc;
  logic [PCT_W-1:0]   pct;
  logic [LEN_W-1:0]   a_len;
  logic [LEN_W-1:0]   top_len;
  logic [LEN_W-1:0]   ld_len;
  logic [LEN_W-1:0]   q_len;
  logic [LPROD_W-1:0] lprod;
  logic [LEN_W-1:0]   lo_quo;
  logic [LEN_W-1:0]   lo_len;
  logic               has_lo;
  logic [ACC_W-1:0]   term;

  lbp_div u_div (
    .clk (clk),
    .rst_n (rst_n),
    .req (div_req),
    .rsp (div_rsp)
  );

  assign in_ready = (state_r == S_LOAD);
  assign in_acc   = in_valid && in_ready;

  // coverage clamped to 1..100
  assign pct = (cov_r == '0) ? PCT_W'(1) :
               (cov_r > PCT_W'(100)) ? PCT_W'(100) : cov_r;

  assign a_len   = LEN_W'(i_r) + LEN_W'(min_len_r);
  assign top_len = LEN_W'(min_len_r) + LEN_W'(n_r) - LEN_W'(1);
  assign ld_len  = LEN_W'(bins_r[IDX_W-1:0]) + LEN_W'(min_len_r);
  assign has_lo  = (kind_r == K_MIN) || ((kind_r == K_NAIVE) && (lidx_r != '0));
  assign term    = ACC_W'(plo_r) + (ACC_W'(phi_r) << LO_MUL_W) + ACC_W'(badd_r);
  assign q_len   = (div_rsp.quotient < DIVN_W'(top_len)) ?
                   div_rsp.quotient[LEN_W-1:0] : top_len;
  // ceil(a*d/100) from the registered numerator a*d+99
  assign lprod   = LPROD_W'(lnum_r) * LPROD_W'(RECIP_100);
  assign lo_quo  = lprod[LPROD_W-1:RECIP_SH];
  assign lo_len  = (lo_quo < LEN_W'(min_len_r)) ? LEN_W'(min_len_r) : lo_quo;

  // divider: upper bound a*100/d, one division per row
  always_comb begin
    div_req.start    = (state_r == S_ROW);
    div_req.dividend = DIVN_W'(a_len) * DIVN_W'(100);
    div_req.divisor  = pct;
  end

  always_comb begin
    case (state_r)
      S_RDU:   rd_addr = uidx_r;
      S_TADDR: rd_addr = (kind_r == K_NAIVE) ? IDX_W'(lidx_r - IDX_W'(1))
                                             : IDX_W'(k_r - IDX_W'(1));
      S_BT_RD: rd_addr = idx_r;
      default: rd_addr = '0;
    endcase
  end

  assign load_we = in_acc && (bins_r < BINS_W'(MAX_BINS));
  assign row_we  = (state_r == S_WRITE);

  always_ff @(posedge clk) begin
    if (load_we) begin
      pc_mem[bins_r[IDX_W-1:0]] <= pc_run_nxt;
      pw_mem[bins_r[IDX_W-1:0]] <= pw_run_nxt;
    end
    if (row_we) begin
      best_mem[i_r] <= best_r;
      bp_mem[i_r]   <= bp_r;
      up_mem[i_r]   <= upper_r;
    end
    pc_q   <= pc_mem[rd_addr];
    pw_q   <= pw_mem[rd_addr];
    best_q <= best_mem[rd_addr];
    bp_q   <= bp_mem[rd_addr];
    up_q   <= up_mem[rd_addr];
  end

  // sequencer
  always_comb begin
    state_nxt     = state_r;
    min_len_nxt   = min_len_r;
    cov_nxt       = cov_r;
    bins_nxt      = bins_r;
    n_nxt         = n_r;
    pc_run_nxt    = pc_run_r;
    pw_run_nxt    = pw_run_r;
    i_nxt         = i_r;
    k_nxt         = k_r;
    kind_nxt      = kind_r;
    upper_nxt     = upper_r;
    uidx_nxt      = uidx_r;
    lidx_nxt      = lidx_r;
    lnum_nxt      = lnum_r;
    wu_nxt        = wu_r;
    cu_nxt        = cu_r;
    wd_nxt        = wd_r;
    cd_nxt        = cd_r;
    badd_nxt      = badd_r;
    plo_nxt       = plo_r;
    phi_nxt       = phi_r;
    best_nxt      = best_r;
    bp_nxt        = bp_r;
    naive_nxt     = naive_r;
    full_nxt      = full_r;
    minc_nxt      = minc_r;
    idx_nxt       = idx_r;
    btbp_nxt      = btbp_r;
    out_valid_nxt = out_valid_r;
    out_low_nxt   = out_low_r;
    out_high_nxt  = out_high_r;
    out_last_nxt  = out_last_r;

    if (cfg_we) begin
      case (cfg_index)
        CFG_MIN_LENGTH: min_len_nxt = cfg_data;
        CFG_COVERAGE:   cov_nxt     = cfg_data[PCT_W-1:0];
        default: ;
      endcase
    end

    // running sums feed both the memory write and the final total cost
    if (load_we) begin
      pc_run_nxt = pc_run_r + CNT_W'(in_bin_count);
      pw_run_nxt = pw_run_r + WSUM_W'(ld_len * 29'(in_bin_count));
      bins_nxt   = bins_r + BINS_W'(1);
    end

    case (state_r)
      S_LOAD: begin
        if (in_acc && in_last_bin) begin
          n_nxt     = load_we ? bins_r + BINS_W'(1) : bins_r;
          i_nxt     = '0;
          naive_nxt = '0;
          state_nxt = S_ROW;
        end
      end
      S_ROW: state_nxt = S_DIVQ;
      S_DIVQ: begin
        if (div_rsp.done) begin
          upper_nxt = q_len;
          uidx_nxt  = IDX_W'(q_len - LEN_W'(min_len_r));
          lnum_nxt  = DIVN_W'(a_len) * DIVN_W'(pct) + DIVN_W'(99);
          state_nxt = S_DIVL;
        end
      end
      S_DIVL: begin
        lidx_nxt  = IDX_W'(lo_len - LEN_W'(min_len_r));
        state_nxt = S_RDU;
      end
      S_RDU: state_nxt = S_LATU;
      S_LATU: begin
        wu_nxt    = pw_q;
        cu_nxt    = pc_q;
        kind_nxt  = K_MIN0;
        k_nxt     = '0;
        state_nxt = S_TADDR;
      end
      S_TADDR: state_nxt = S_TDATA;
      S_TDATA: begin
        if (kind_r == K_FULL) begin
          wd_nxt = pw_run_r;
          cd_nxt = pc_run_r + CNT_W'(1);
        end else begin
          wd_nxt = has_lo ? wu_r - pw_q : wu_r;
          cd_nxt = has_lo ? cu_r + CNT_W'(1) - pc_q : cu_r + CNT_W'(1);
        end
        badd_nxt  = (kind_r == K_MIN) ? best_q : '0;
        state_nxt = S_TMUL0;
      end
      S_TMUL0: begin
        plo_nxt   = wd_r[LO_MUL_W-1:0] * cd_r;
        state_nxt = S_TMUL1;
      end
      S_TMUL1: begin
        phi_nxt   = wd_r[WSUM_W-1:LO_MUL_W] * cd_r;
        state_nxt = S_TACC;
      end
      S_TACC: begin
        state_nxt = S_TADDR;
        case (kind_r)
          K_MIN0: begin
            best_nxt = term[COST_W-1:0];
            bp_nxt   = '0;
            if (i_r == '0) begin
              kind_nxt = K_NAIVE;
            end else begin
              kind_nxt = K_MIN;
              k_nxt    = IDX_W'(1);
            end
          end
          K_MIN: begin
            // strict compare keeps the earliest split on ties
            if (ACC_W'(best_r) > term) begin
              best_nxt = term[COST_W-1:0];
              bp_nxt   = k_r;
            end
            if (k_r == i_r) kind_nxt = K_NAIVE;
            else k_nxt = k_r + IDX_W'(1);
          end
          K_NAIVE: begin
            naive_nxt = naive_r + TOT_W'(term);
            state_nxt = S_WRITE;
          end
          default: begin
            full_nxt  = term[COST_W-1:0];
            idx_nxt   = IDX_W'(n_r - BINS_W'(1));
            state_nxt = S_BT_RD;
          end
        endcase
      end
      S_WRITE: begin
        if (BINS_W'(i_r) == n_r - BINS_W'(1)) begin
          minc_nxt  = best_r;
          kind_nxt  = K_FULL;
          state_nxt = S_TDATA;
        end else begin
          i_nxt     = i_r + IDX_W'(1);
          state_nxt = S_ROW;
        end
      end
      S_BT_RD: state_nxt = S_BT_OUT;
      S_BT_OUT: begin
        out_low_nxt   = (bp_q == '0) ? LEN_W'(min_len_r)
                                     : LEN_W'(bp_q) + LEN_W'(min_len_r);
        out_high_nxt  = up_q;
        out_last_nxt  = (bp_q == '0);
        out_valid_nxt = 1'b1;
        btbp_nxt      = bp_q;
        state_nxt     = S_BT_WAIT;
      end
      S_BT_WAIT: begin
        if (out_ready) begin
          out_valid_nxt = 1'b0;
          if (btbp_r == '0) begin
            bins_nxt   = '0;
            pc_run_nxt = '0;
            pw_run_nxt = '0;
            naive_nxt  = '0;
            state_nxt  = S_LOAD;
          end else begin
            idx_nxt   = btbp_r - IDX_W'(1);
            state_nxt = S_BT_RD;
          end
        end
      end
      default: state_nxt = S_LOAD;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= S_LOAD;
      min_len_r   <= ML_W'(1);
      cov_r       <= PCT_W'(90);
      bins_r      <= '0;
      pc_run_r    <= '0;
      pw_run_r    <= '0;
      naive_r     <= '0;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      min_len_r   <= min_len_nxt;
      cov_r       <= cov_nxt;
      bins_r      <= bins_nxt;
      pc_run_r    <= pc_run_nxt;
      pw_run_r    <= pw_run_nxt;
      naive_r     <= naive_nxt;
      out_valid_r <= out_valid_nxt;
    end
    n_r        <= n_nxt;
    i_r        <= i_nxt;
    k_r        <= k_nxt;
    kind_r     <= kind_nxt;
    upper_r    <= upper_nxt;
    uidx_r     <= uidx_nxt;
    lidx_r     <= lidx_nxt;
    lnum_r     <= lnum_nxt;
    wu_r       <= wu_nxt;
    cu_r       <= cu_nxt;
    wd_r       <= wd_nxt;
    cd_r       <= cd_nxt;
    badd_r     <= badd_nxt;
    plo_r      <= plo_nxt;
    phi_r      <= phi_nxt;
    best_r     <= best_nxt;
    bp_r       <= bp_nxt;
    full_r     <= full_nxt;
    minc_r     <= minc_nxt;
    idx_r      <= idx_nxt;
    btbp_r     <= btbp_nxt;
    out_low_r  <= out_low_nxt;
    out_high_r <= out_high_nxt;
    out_last_r <= out_last_nxt;
  end

  assign out_valid         = out_valid_r;
  assign out_interval_low  = out_low_r;
  assign out_interval_high = out_high_r;
  assign out_min_cost      = TOT_W'(minc_r);
  assign out_naive_cost    = naive_r;
  assign out_full_cost     = TOT_W'(full_r);
  assign out_last_interval = out_last_r;

endmodule

// File: sv/lbp_checker.sv
// Port-level checks for the length-bucket partitioner, bound to the top level.
// Depends on lbp_pkg for widths.
module lbp_checker (
  input logic                      clk,
  input logic                      rst_n,
  input logic                      in_ready,
  input logic                      out_valid,
  input logic                      out_ready,
  input logic [lbp_pkg::LEN_W-1:0] out_interval_low,
  input logic [lbp_pkg::LEN_W-1:0] out_interval_high,
  input logic [lbp_pkg::TOT_W-1:0] out_min_cost,
  input logic                      out_last_interval
);

  // stalled result holds
  a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && !out_ready |=> out_valid && $stable(out_interval_low)
      && $stable(out_min_cost))
    else $error("result changed under stall");

  // loading and emitting never overlap
  a_no_overlap: assert property (@(posedge clk) disable iff (!rst_n)
    !(in_ready && out_valid))
    else $error("input taken while a result is pending");

  a_order: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid |-> out_interval_low <= out_interval_high)
    else $error("interval low above high");

  // after the final interval the block goes back to loading
  a_last_done: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_ready && out_last_interval |=> !out_valid && in_ready)
    else $error("no return to load after final interval");

  a_reset: assert property (@(posedge clk) !rst_n |=> !out_valid)
    else $error("result valid after reset");

endmodule

bind length_bucket_partition_dp lbp_checker u_lbp_checker (
  .clk (clk),
  .rst_n (rst_n),
  .in_ready (in_ready),
  .out_valid (out_valid),
  .out_ready (out_ready),
  .out_interval_low (out_interval_low),
  .out_interval_high (out_interval_high),
  .out_min_cost (out_min_cost),
  .out_last_interval (out_last_interval)
);

// File: test/tb_top.sv
// Self-checking testbench for length_bucket_partition_dp: loads directed and random histograms,
// predicts the emitted buckets and costs, and compares every output transaction.
// Depends on lbp_pkg and the block's RTL.
module tb_top;
  timeunit 1ns;
  timeprecision 1ps;
  import lbp_pkg::*;

  // one emitted bucket
  typedef struct {
    logic [LEN_W-1:0] low;
    logic [LEN_W-1:0] high;
    logic [TOT_W-1:0] minc;
    logic [TOT_W-1:0] naive;
    logic [TOT_W-1:0] full;
    logic             last;
  } bucket_t;

  // one histogram bin transaction
  typedef struct {
    logic [15:0] cnt;
    logic        last;
  } bin_t;

  logic clk = 1'b0;
  logic rst_n = 1'b0;
  logic in_valid = 1'b0;
  logic in_ready;
  logic [15:0] in_bin_count = '0;
  logic in_last_bin = 1'b0;
  logic out_valid;
  logic out_ready = 1'b0;
  logic [LEN_W-1:0] out_interval_low, out_interval_high;
  logic [TOT_W-1:0] out_min_cost, out_naive_cost, out_full_cost;
  logic out_last_interval;
  logic cfg_we = 1'b0;
  logic cfg_index = CFG_MIN_LENGTH;
  logic [ML_W-1:0] cfg_data = '0;

  length_bucket_partition_dp dut (.*);

  always begin
    #5 clk = 1'b1;
    #5 clk = 1'b0;
  end

  // predictor state, mirrors the block's registers
  logic [ML_W-1:0]  pm_min_len;
  logic [PCT_W-1:0] pm_cov;
  logic [63:0]      pm_pc[MAX_BINS];
  logic [63:0]      pm_pw[MAX_BINS];
  logic [63:0]      pm_best[MAX_BINS];
  int unsigned      pm_bp[MAX_BINS];
  int unsigned      pm_nbins;

  bin_t    bins_pending[$];
  bucket_t buckets_expected[$];
  int      errors = 0;
  int      send_idle_pct = 0;
  int      recv_idle_pct = 0;
  int      hold_off_cycles = 0;

  function automatic int unsigned eff_pct();
    if (pm_cov == 0) return 1;
    if (pm_cov > 100) return 100;
    return pm_cov;
  endfunction

  function automatic logic [63:0] span_cost(int unsigned lo, int unsigned hi);
    logic [63:0] w, c;
    w = pm_pw[hi];
    c = pm_pc[hi] + 1;
    if (lo > 0) begin
      w -= pm_pw[lo-1];
      c -= pm_pc[lo-1];
    end
    return w * c;
  endfunction

  function automatic int unsigned upper_length(int unsigned a, int unsigned n);
    int unsigned q, top;
    q = (a * 100) / eff_pct();
    top = pm_min_len + n - 1;
    return (q < top) ? q : top;
  endfunction

  // load one bin; on the last bin solve and queue the buckets
  function automatic void predict_bin(bin_t b);
    int unsigned n, i, k, a, u, lo, idx, bp, cnt_out;
    logic [63:0] m, naive, full, minc;
    bucket_t bk;
    if (pm_nbins < MAX_BINS) begin
      pm_pc[pm_nbins] = (pm_nbins > 0 ? pm_pc[pm_nbins-1] : 64'd0) + b.cnt;
      pm_pw[pm_nbins] = (pm_nbins > 0 ? pm_pw[pm_nbins-1] : 64'd0)
                        + 64'(pm_nbins + pm_min_len) * b.cnt;
      pm_nbins++;
    end
    if (!b.last) return;
    n = pm_nbins;
    naive = 0;
    for (i = 0; i < n; i++) begin
      a = i + pm_min_len;
      u = upper_length(a, n) - pm_min_len;
      lo = (a * eff_pct() + 99) / 100;
      if (lo < pm_min_len) lo = pm_min_len;
      pm_best[i] = span_cost(0, u);
      pm_bp[i] = 0;
      for (k = 1; k <= i; k++) begin
        m = span_cost(k, u) + pm_best[k-1];
        if (pm_best[i] > m) begin
          pm_best[i] = m;
          pm_bp[i] = k;
        end
      end
      naive += span_cost(lo - pm_min_len, u);
    end
    full = span_cost(0, n - 1);
    minc = pm_best[n-1];
    idx = n - 1;
    cnt_out = 0;
    forever begin
      bp = pm_bp[idx];
      bk.low = LEN_W'(bp ? bp + pm_min_len : pm_min_len);
      bk.high = LEN_W'(upper_length(idx + pm_min_len, n));
      bk.minc = minc[TOT_W-1:0];
      bk.naive = naive[TOT_W-1:0];
      bk.full = full[TOT_W-1:0];
      cnt_out++;
      bk.last = (bp == 0 || cnt_out >= MAX_BINS);
      buckets_expected.insert(buckets_expected.size(), bk);
      if (bk.last) break;
      idx = bp - 1;
    end
    pm_nbins = 0;
  endfunction

  // driver: valid held with stable payload until accepted
  always @(posedge clk) begin
    if (!rst_n) begin
      in_valid <= 1'b0;
    end else if (!in_valid || in_ready) begin
      if (in_valid) predict_bin('{in_bin_count, in_last_bin});
      if (bins_pending.size() > 0 && $urandom_range(99) >= send_idle_pct) begin
        bin_t b;
        b = bins_pending.pop_front();
        in_valid <= 1'b1;
        in_bin_count <= b.cnt;
        in_last_bin <= b.last;
      end else begin
        in_valid <= 1'b0;
      end
    end
  end

  // monitor and sink
  always @(posedge clk) begin
    if (rst_n) begin
      if (out_valid && out_ready) begin
        if (buckets_expected.size() == 0) begin
          $display("%0t: bucket exp none got low=%0d high=%0d", $time,
                   out_interval_low, out_interval_high);
          errors++;
        end else begin
          bucket_t e;
          e = buckets_expected.pop_front();
          if (out_interval_low !== e.low) begin
            $display("%0t: interval_low exp %0d got %0d", $time, e.low, out_interval_low);
            errors++;
          end
          if (out_interval_high !== e.high) begin
            $display("%0t: interval_high exp %0d got %0d", $time, e.high,
                     out_interval_high);
            errors++;
          end
          if (out_min_cost !== e.minc) begin
            $display("%0t: min_cost exp %0d got %0d", $time, e.minc, out_min_cost);
            errors++;
          end
          if (out_naive_cost !== e.naive) begin
            $display("%0t: naive_cost exp %0d got %0d", $time, e.naive, out_naive_cost);
            errors++;
          end
          if (out_full_cost !== e.full) begin
            $display("%0t: full_cost exp %0d got %0d", $time, e.full, out_full_cost);
            errors++;
          end
          if (out_last_interval !== e.last) begin
            $display("%0t: last_interval exp %0b got %0b", $time, e.last,
                     out_last_interval);
            errors++;
          end
        end
      end
      // long hold-off counted here so the block backs up
      if (hold_off_cycles > 0) begin
        hold_off_cycles <= hold_off_cycles - 1;
        out_ready <= 1'b0;
      end else begin
        out_ready <= ($urandom_range(99) >= recv_idle_pct);
      end
    end
  end

  task automatic write_reg(input logic idx, input int unsigned val);
    @(posedge clk);
    cfg_we <= 1'b1;
    cfg_index <= idx;
    cfg_data <= ML_W'(val);
    if (idx == CFG_MIN_LENGTH) pm_min_len = ML_W'(val);
    else pm_cov = PCT_W'(val);
    @(posedge clk);
    cfg_we <= 1'b0;
  endtask

  // wait for the block to drain the queued histograms
  task automatic drain();
    while (bins_pending.size() > 0 || in_valid || buckets_expected.size() > 0)
      @(posedge clk);
    repeat (20) @(posedge clk);
  endtask

  // one histogram job; n bins plus the last flag on the final one
  task automatic queue_job(input int n, input int mode);
    bin_t b;
    for (int i = 0; i < n; i++) begin
      case (mode)
        0: b.cnt = 16'($urandom);
        1: b.cnt = 16'hFFFF;
        2: b.cnt = 16'd0;
        default: b.cnt = ($urandom_range(3) == 0) ? 16'($urandom) : 16'($urandom_range(20));
      endcase
      b.last = (i == n - 1);
      bins_pending.insert(bins_pending.size(), b);
    end
  endtask

  task automatic random_phase(input int items);
    int sent;
    int n;
    sent = 0;
    while (sent < items) begin
      n = ($urandom_range(9) == 0) ? $urandom_range(70, 40) : $urandom_range(12, 1);
      queue_job(n, $urandom_range(3));
      sent += n;
    end
  endtask

  initial begin
    pm_min_len = 1;
    pm_cov = 90;
    pm_nbins = 0;
    repeat (8) @(posedge clk);
    rst_n <= 1'b1;
    // directed: single bin, zero counts, full counts, overflow past capacity
    queue_job(1, 1);
    queue_job(3, 2);
    queue_job(4, 1);
    queue_job(16, 0);
    drain();
    write_reg(CFG_MIN_LENGTH, 0);
    write_reg(CFG_COVERAGE, 0);
    queue_job(5, 0);
    drain();
    write_reg(CFG_MIN_LENGTH, 4095);
    write_reg(CFG_COVERAGE, 127);
    queue_job(66, 1);  // two bins dropped past capacity
    drain();
    write_reg(CFG_COVERAGE, 100);
    queue_job(6, 3);
    drain();
    write_reg(CFG_MIN_LENGTH, 1);
    write_reg(CFG_COVERAGE, 1);
    queue_job(8, 0);
    drain();
    // random phases with different settings and idling
    send_idle_pct = 16; recv_idle_pct = 72;
    write_reg(CFG_MIN_LENGTH, $urandom_range(4095, 1));
    write_reg(CFG_COVERAGE, $urandom_range(100, 50));
    random_phase(70);
    drain();
    send_idle_pct = 72; recv_idle_pct = 16;
    write_reg(CFG_MIN_LENGTH, $urandom_range(200, 1));
    write_reg(CFG_COVERAGE, $urandom_range(100, 1));
    random_phase(70);
    drain();
    send_idle_pct = 0; recv_idle_pct = 0;
    write_reg(CFG_MIN_LENGTH, 10);
    write_reg(CFG_COVERAGE, 90);
    hold_off_cycles = 3000;  // sink stalls while jobs keep coming
    random_phase(70);
    drain();
    if (errors == 0) $display("Regression PASS");
    else $display("Regression FAIL");
    $finish;
  end

  initial begin
    #50ms;
    $display("Regression FAIL");
    $finish;
  end
endmodule

// File: length_bucket_partition_dp.f
sv/lbp_pkg.sv
sv/lbp_div.sv
sv/length_bucket_partition_dp.sv
sv/lbp_checker.sv
test/tb_top.sv
